[src/sdspi_pkg.sv]
// Shared types, phase codes and constants of the SD SPI command engine.
package sdspi_pkg;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_WAKE = 4'd1;
    localparam logic [3:0] PH_BUSY = 4'd2;
    localparam logic [3:0] PH_SEND = 4'd3;
    localparam logic [3:0] PH_RESP = 4'd4;

    localparam logic [1:0] FN_CMD  = 2'd0;
    localparam logic [1:0] FN_INIT = 2'd1;
    localparam logic [1:0] FN_RX   = 2'd2;
    localparam logic [1:0] FN_TICK = 2'd3;

    localparam logic [1:0] REG_BUSY_WAIT    = 2'd0;
    localparam logic [1:0] REG_INIT_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_WAKE_BYTES   = 2'd2;

    localparam logic [15:0] BUSY_WAIT_RESET    = 16'd300;
    localparam logic [15:0] INIT_TIMEOUT_RESET = 16'd2000;
    localparam logic [7:0]  WAKE_BYTES_RESET   = 8'd10;

    localparam logic [7:0]  CMD_START   = 8'h40;
    localparam logic [7:0]  CRC_CMD0    = 8'h95;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  FILL_BYTE   = 8'hFF;
    localparam logic [5:0]  CMD_APP     = 6'd55;
    localparam logic [5:0]  CMD_IDLE    = 6'd0;
    localparam logic [5:0]  CMD_IF_COND = 6'd8;
    localparam logic [8:0]  FRAME_LAST  = 9'd5;
    localparam logic [8:0]  RESP_LIMIT  = 9'd255;
    localparam logic [7:0]  R1_IDLE     = 8'h01;
    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  command_index;
        logic [31:0] argument;
        logic        app_command;
        logic [7:0]  rx_byte;
    } in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_low;
        logic       done_res;
        logic [7:0] r1_status;
        logic       init_error;
    } out_t;

    typedef struct packed {
        logic [15:0] busy_wait_ms;
        logic [15:0] init_timeout_ms;
        logic [7:0]  wake_bytes;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  phase;
        logic [8:0]  byte_counter;
        logic [15:0] busy_elapsed;
        logic [15:0] init_elapsed;
        logic [5:0]  command_hold;
        logic [31:0] argument_hold;
        logic        prefix_pending;
        logic        init_mode;
        logic [7:0]  last_response;
        logic        select_level;
    } state_t;

    // Idle, counters cleared, chip select high.
    localparam state_t STATE_RESET = '{
        phase:          PH_IDLE,
        byte_counter:   9'd0,
        busy_elapsed:   16'd0,
        init_elapsed:   16'd0,
        command_hold:   6'd0,
        argument_hold:  32'd0,
        prefix_pending: 1'b0,
        init_mode:      1'b0,
        last_response:  8'd0,
        select_level:   1'b1
    };

endpackage

[src/sdspi_step.sv]
// Next-state and result logic for one event of the SD SPI command engine.
module sdspi_step
    import sdspi_pkg::*;
(
    input  state_t st,
    input  in_t    item,
    input  cfg_t   cfg,
    output state_t nxt,
    output logic   res_valid,
    output out_t   res
);

    logic       tx_v;
    logic [7:0] tx_b;
    logic       done;
    logic       err;
    logic [5:0] cur_cmd;
    logic [31:0] cur_arg;
    logic [8:0] cnt_inc;

    // Byte k of the command frame: start+index, four argument bytes, then CRC or 0xFF fill.
    function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] c,
                                             input logic [31:0] a);
        logic [7:0] b;
        case (k)
            3'd0:    b = CMD_START | {2'b00, c};
            3'd1:    b = a[31:24];
            3'd2:    b = a[23:16];
            3'd3:    b = a[15:8];
            3'd4:    b = a[7:0];
            default:
            begin
                if (c == CMD_IDLE)
                    b = CRC_CMD0;
                else if (c == CMD_IF_COND)
                    b = CRC_CMD8;
                else
                    b = FILL_BYTE;
            end
        endcase
        return b;
    endfunction

    assign cur_cmd = st.prefix_pending ? CMD_APP : st.command_hold;
    assign cur_arg = st.prefix_pending ? 32'd0 : st.argument_hold;
    assign cnt_inc = st.byte_counter + 9'd1;

    always_comb
    begin
        logic start_wait;
        nxt        = st;
        res_valid  = 1'b0;
        tx_v       = 1'b1;
        tx_b       = FILL_BYTE;
        done       = 1'b0;
        err        = 1'b0;
        start_wait = 1'b0;
        case (item.func)
            FN_TICK:
            begin
                if (st.busy_elapsed != ELAPSED_MAX)
                    nxt.busy_elapsed = st.busy_elapsed + 16'd1;
                if (st.init_elapsed != ELAPSED_MAX)
                    nxt.init_elapsed = st.init_elapsed + 16'd1;
            end
            FN_CMD:
            begin
                if (st.phase == PH_IDLE)
                begin
                    nxt.command_hold   = item.command_index;
                    nxt.argument_hold  = item.argument;
                    nxt.prefix_pending = item.app_command;
                    nxt.init_mode      = 1'b0;
                    start_wait         = 1'b1;
                end
            end
            FN_INIT:
            begin
                if (st.phase == PH_IDLE)
                begin
                    nxt.command_hold   = '0;
                    nxt.argument_hold  = '0;
                    nxt.prefix_pending = 1'b0;
                    nxt.init_mode      = 1'b1;
                    nxt.init_elapsed   = '0;
                    if (cfg.wake_bytes == 8'd0)
                        start_wait = 1'b1;
                    else
                    begin
                        nxt.select_level = 1'b1;
                        nxt.phase        = PH_WAKE;
                        nxt.byte_counter = '0;
                        res_valid        = 1'b1;
                    end
                end
            end
            default:
            begin
                case (st.phase)
                    PH_WAKE:
                    begin
                        nxt.byte_counter = cnt_inc;
                        if (cnt_inc < {1'b0, cfg.wake_bytes})
                            res_valid = 1'b1;
                        else
                            start_wait = 1'b1;
                    end
                    PH_BUSY:
                    begin
                        res_valid = 1'b1;
                        if (!(item.rx_byte != FILL_BYTE && st.busy_elapsed < cfg.busy_wait_ms))
                        begin
                            nxt.phase        = PH_SEND;
                            nxt.byte_counter = '0;
                            tx_b             = frame_byte(3'd0, cur_cmd, cur_arg);
                        end
                    end
                    PH_SEND:
                    begin
                        res_valid = 1'b1;
                        if (cnt_inc <= FRAME_LAST)
                        begin
                            nxt.byte_counter = cnt_inc;
                            tx_b             = frame_byte(cnt_inc[2:0], cur_cmd, cur_arg);
                        end
                        else
                        begin
                            nxt.phase        = PH_RESP;
                            nxt.byte_counter = '0;
                        end
                    end
                    PH_RESP:
                    begin
                        nxt.last_response = item.rx_byte;
                        if (item.rx_byte[7] && st.byte_counter < RESP_LIMIT)
                        begin
                            nxt.byte_counter = cnt_inc;
                            res_valid        = 1'b1;
                        end
                        else
                        begin
                            nxt.byte_counter = '0;
                            if (st.prefix_pending)
                            begin
                                nxt.prefix_pending = 1'b0;
                                start_wait         = 1'b1;
                            end
                            else if (st.init_mode)
                            begin
                                if (item.rx_byte == R1_IDLE ||
                                    st.init_elapsed > cfg.init_timeout_ms)
                                begin
                                    nxt.init_mode    = 1'b0;
                                    nxt.phase        = PH_IDLE;
                                    nxt.select_level = 1'b1;
                                    res_valid        = 1'b1;
                                    tx_v             = 1'b0;
                                    done             = 1'b1;
                                    err              = (item.rx_byte != R1_IDLE);
                                end
                                else
                                    start_wait = 1'b1;
                            end
                            else
                            begin
                                nxt.phase = PH_IDLE;
                                res_valid = 1'b1;
                                tx_v      = 1'b0;
                                done      = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        endcase
        if (start_wait)
        begin
            nxt.select_level = 1'b0;
            nxt.phase        = PH_BUSY;
            nxt.byte_counter = '0;
            nxt.busy_elapsed = '0;
            res_valid        = 1'b1;
            tx_v             = 1'b1;
            tx_b             = FILL_BYTE;
        end
    end

    assign res.tx_valid   = tx_v;
    assign res.tx_byte    = tx_v ? tx_b : 8'd0;
    assign res.cs_low     = ~nxt.select_level;
    assign res.done_res   = done;
    assign res.r1_status  = nxt.last_response;
    assign res.init_error = err;

endmodule

[src/sd_spi_command_engine_unit.sv]
// Top level of the SD SPI command engine: state, configuration and output buffering.
// A result is registered in the result register, or parked in the skid entry while that register is held.
// Throughput: one input transaction per cycle while in_stall is low; the event logic is one pass per item.
// A two-entry output buffer (result register plus skid) lets input keep flowing
// while out_stall is high until the skid fills; in_stall rises only when both are full.
// Reset (rst_n low, asynchronous): sequencer idle, CS high, counters cleared,
// registers back to busy wait 300 ms, init timeout 2000 ms, 10 wake bytes.
module sd_spi_command_engine_unit
    import sdspi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;

    logic   res_valid;
    out_t   res;

    logic   main_valid_reg, main_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    out_t   main_reg, main_next;
    out_t   skid_reg, skid_next;

    logic   in_take;
    logic   out_take;

    // Accept whenever the skid entry is free; the result register may still hold.
    assign in_stall  = skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign out_take  = main_valid_reg && !out_stall;

    sdspi_step u_step
    (
        .st        (state_reg),
        .item      (in_data),
        .cfg       (cfg_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    // Configuration writes land directly; unknown indexes drop.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.busy_wait_ms    <= BUSY_WAIT_RESET;
            cfg_reg.init_timeout_ms <= INIT_TIMEOUT_RESET;
            cfg_reg.wake_bytes      <= WAKE_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BUSY_WAIT:    cfg_reg.busy_wait_ms    <= cfg_data;
                REG_INIT_TIMEOUT: cfg_reg.init_timeout_ms <= cfg_data;
                REG_WAKE_BYTES:   cfg_reg.wake_bytes      <= cfg_data[7:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Advance the sequencer state on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    // Output buffer: drain main first, refill from skid, park a new result in
    // skid only when main is occupied and not draining.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
                main_valid_next = 1'b0;
        end
        if (in_take && res_valid)
        begin
            if (!main_valid_reg || out_take)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload without reset.
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    // A parked skid result always sits behind a valid result register.
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while result register empty");

    // A finished sequence never asks for a transfer.
    a_done_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && main_reg.done_res) |->
        (!main_reg.tx_valid && main_reg.tx_byte == 8'd0))
        else $error("done result carries a transfer byte");

    // Wake bytes go out with chip select high.
    a_wake_cs_high: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_WAKE) |-> state_reg.select_level)
        else $error("chip select low during wake bytes");

    // Any accepted transaction into a full buffer must not be lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("skid entry dropped while output stalled");

endmodule

[tb/tb_sd_spi_command_engine_unit.sv]
// Self-checking testbench for the SD SPI command engine: directed cases, then random card traffic.
module tb_sd_spi_command_engine_unit;
    import sdspi_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int SAT_TICKS     = 40;      // ticks spent inside the largest-timeout init

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_BUSY_WAIT;
    logic [15:0] cfg_data = '0;

    sd_spi_command_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mirror of the sequencer state, advanced once per accepted input transaction.
    cfg_t        eng_cfg;
    logic [3:0]  eng_phase;
    logic [8:0]  eng_count;
    logic [15:0] eng_busy_ms;
    logic [15:0] eng_init_ms;
    logic [5:0]  eng_cmd;
    logic [31:0] eng_arg;
    logic        eng_prefix;
    logic        eng_init;
    logic [7:0]  eng_r1;
    logic        eng_cs_high;

    out_t        spi_out_due[$];    // SPI bytes and status words still to come out
    int          mismatch_count = 0;
    int          effective_count = 0;
    int unsigned cycle_count = 0;
    bit          in_idle_on = 1'b1;
    bit          out_stall_on = 1'b1;
    int          stall_left = 0;

    function automatic void reset_model();
        eng_cfg.busy_wait_ms    = BUSY_WAIT_RESET;
        eng_cfg.init_timeout_ms = INIT_TIMEOUT_RESET;
        eng_cfg.wake_bytes      = WAKE_BYTES_RESET;
        eng_phase   = PH_IDLE;
        eng_count   = '0;
        eng_busy_ms = '0;
        eng_init_ms = '0;
        eng_cmd     = '0;
        eng_arg     = '0;
        eng_prefix  = 1'b0;
        eng_init    = 1'b0;
        eng_r1      = '0;
        eng_cs_high = 1'b1;
    endfunction

    // Pack the visible outputs from the current mirror state.
    function automatic out_t make_out(logic v, logic [7:0] b, logic fin, logic err);
        out_t r;
        r.tx_valid   = v;
        r.tx_byte    = v ? b : 8'h00;
        r.cs_low     = ~eng_cs_high;
        r.done_res   = fin;
        r.r1_status  = eng_r1;
        r.init_error = err;
        return r;
    endfunction

    // Lower CS and poll for not-busy from a fresh busy timer.
    function automatic out_t start_busy_poll();
        eng_cs_high = 1'b0;
        eng_phase   = PH_BUSY;
        eng_count   = '0;
        eng_busy_ms = '0;
        return make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
    endfunction

    // Byte k of the six-byte command frame; a pending prefix sends cmd55 with zero argument.
    function automatic logic [7:0] frame_byte(logic [8:0] k);
        logic [5:0]  c;
        logic [31:0] a;
        c = eng_prefix ? CMD_APP : eng_cmd;
        a = eng_prefix ? 32'd0 : eng_arg;
        if (k == 0)
            return {2'b00, c} | CMD_START;
        if (k <= 4)
            return a[8 * (4 - k) +: 8];
        if (c == CMD_IDLE)
            return CRC_CMD0;
        if (c == CMD_IF_COND)
            return CRC_CMD8;
        return FILL_BYTE;
    endfunction

    // Advance the mirror by one transaction; return 1 when a result is due.
    function automatic bit predict_spi_out(input in_t t, output out_t r);
        bit has;
        has = 1'b1;
        r = '0;
        case (t.func)
            FN_TICK:
            begin
                if (eng_busy_ms != ELAPSED_MAX)
                    eng_busy_ms++;
                if (eng_init_ms != ELAPSED_MAX)
                    eng_init_ms++;
                has = 1'b0;
            end
            FN_CMD:
            begin
                if (eng_phase != PH_IDLE)
                    has = 1'b0;
                else
                begin
                    eng_cmd    = t.command_index;
                    eng_arg    = t.argument;
                    eng_prefix = t.app_command;
                    eng_init   = 1'b0;
                    r = start_busy_poll();
                end
            end
            FN_INIT:
            begin
                if (eng_phase != PH_IDLE)
                    has = 1'b0;
                else
                begin
                    eng_cmd     = '0;
                    eng_arg     = '0;
                    eng_prefix  = 1'b0;
                    eng_init    = 1'b1;
                    eng_init_ms = '0;
                    if (eng_cfg.wake_bytes == 0)
                        r = start_busy_poll();
                    else
                    begin
                        eng_cs_high = 1'b1;
                        eng_phase   = PH_WAKE;
                        eng_count   = '0;
                        r = make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
                    end
                end
            end
            default:
            begin
                case (eng_phase)
                    PH_WAKE:
                    begin
                        eng_count++;
                        if (eng_count < eng_cfg.wake_bytes)
                            r = make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
                        else
                            r = start_busy_poll();
                    end
                    PH_BUSY:
                    begin
                        if (t.rx_byte != FILL_BYTE && eng_busy_ms < eng_cfg.busy_wait_ms)
                            r = make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
                        else
                        begin
                            eng_phase = PH_SEND;
                            eng_count = '0;
                            r = make_out(1'b1, frame_byte(eng_count), 1'b0, 1'b0);
                        end
                    end
                    PH_SEND:
                    begin
                        eng_count++;
                        if (eng_count <= FRAME_LAST)
                            r = make_out(1'b1, frame_byte(eng_count), 1'b0, 1'b0);
                        else
                        begin
                            eng_phase = PH_RESP;
                            eng_count = '0;
                            r = make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
                        end
                    end
                    PH_RESP:
                    begin
                        eng_r1 = t.rx_byte;
                        if (t.rx_byte[7] && eng_count < RESP_LIMIT)
                        begin
                            eng_count++;
                            r = make_out(1'b1, FILL_BYTE, 1'b0, 1'b0);
                        end
                        else
                        begin
                            eng_count = '0;
                            if (eng_prefix)
                            begin
                                eng_prefix = 1'b0;
                                r = start_busy_poll();
                            end
                            else if (eng_init)
                            begin
                                if (t.rx_byte == R1_IDLE || eng_init_ms > eng_cfg.init_timeout_ms)
                                begin
                                    // Init ends either way and releases CS.
                                    eng_init    = 1'b0;
                                    eng_phase   = PH_IDLE;
                                    eng_cs_high = 1'b1;
                                    r = make_out(1'b0, 8'h00, 1'b1, t.rx_byte != R1_IDLE);
                                end
                                else
                                    r = start_busy_poll();
                            end
                            else
                            begin
                                // Command done leaves CS low.
                                eng_phase = PH_IDLE;
                                r = make_out(1'b0, 8'h00, 1'b1, 1'b0);
                            end
                        end
                    end
                    default:
                        has = 1'b0;
                endcase
            end
        endcase
        return has;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fill every field at random, then set the function code.
    function automatic in_t rand_item(logic [1:0] f);
        in_t         t;
        logic [31:0] w;
        w = $urandom;
        t.command_index = w[5:0];
        t.app_command   = w[8];
        t.rx_byte       = w[23:16];
        t.argument      = $urandom;
        t.func          = f;
        return t;
    endfunction

    // Present one transaction, hold it until accepted, then predict its result.
    task automatic send_txn(input in_t t);
        int   gap;
        out_t r;
        gap = (in_idle_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_spi_out(t, r))
        begin
            spi_out_due.push_back(r);
            effective_count++;
        end
        else if (t.func == FN_TICK)
            effective_count++;
    endtask

    // Drop valid and wait until every predicted result has been drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (spi_out_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register while the engine is idle; junk upper bits on the 8-bit register.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] junk;
        settle();
        junk = $urandom;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (idx == REG_WAKE_BYTES) ? {junk[7:0], val[7:0]} : val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_BUSY_WAIT:    eng_cfg.busy_wait_ms = val;
            REG_INIT_TIMEOUT: eng_cfg.init_timeout_ms = val;
            REG_WAKE_BYTES:   eng_cfg.wake_bytes = val[7:0];
            default: ;
        endcase
    endtask

    task automatic start_command(input logic [5:0] idx, input logic [31:0] arg, input logic app);
        in_t t;
        t = rand_item(FN_CMD);
        t.command_index = idx;
        t.argument      = arg;
        t.app_command   = app;
        send_txn(t);
    endtask

    // Play a well-behaved card until the sequence ends: one busy answer then 0xFF,
    // polls bytes with bit 7 set before each R1, first R1 then the rest.
    task automatic drive_card(input logic [7:0] r1_first, input logic [7:0] r1_rest,
                              input int polls);
        in_t t;
        bit  first;
        bit  busy_once;
        first = 1'b1;
        busy_once = 1'b0;
        while (eng_phase != PH_IDLE)
        begin
            t = rand_item(FN_RX);
            case (eng_phase)
                PH_BUSY:
                begin
                    t.rx_byte = busy_once ? FILL_BYTE : 8'h3C;
                    busy_once = ~busy_once;
                end
                PH_RESP:
                begin
                    if (eng_count < polls)
                        t.rx_byte[7] = 1'b1;
                    else
                    begin
                        t.rx_byte = first ? r1_first : r1_rest;
                        first = 1'b0;
                    end
                end
                default: ;
            endcase
            send_txn(t);
        end
    endtask

    // Random card answer that fits the current phase most of the time.
    function automatic logic [7:0] random_card_byte();
        logic [31:0] w;
        w = $urandom;
        case (eng_phase)
            PH_BUSY:
                return (w[31:28] < 4'd6) ? FILL_BYTE : w[7:0];
            PH_RESP:
            begin
                if (w[31:25] < 7'd45)
                    return {1'b1, w[6:0]};
                if (eng_init && w[24])
                    return R1_IDLE;
                return {1'b0, w[6:0]};
            end
            default:
                return w[7:0];
        endcase
    endfunction

    // Default registers: cmd8 with app prefix, all-ones argument, busy card first.
    task automatic test_command_frame();
        start_command(CMD_IF_COND, 32'hFFFF_FFFF, 1'b1);
        drive_card(R1_IDLE, 8'h00, 2);
    endtask

    // Byte and tick while idle, requests while a command runs.
    task automatic test_ignored_items();
        send_txn(rand_item(FN_RX));
        send_txn(rand_item(FN_TICK));
        start_command(6'd63, 32'h8000_0001, 1'b0);
        send_txn(rand_item(FN_INIT));
        send_txn(rand_item(FN_CMD));
        send_txn(rand_item(FN_TICK));
        drive_card(8'h00, 8'h00, 0);
    endtask

    // Wake bytes and a cmd0 retry to success, then a timed-out init with no wake
    // bytes and a single busy poll.
    task automatic test_init_sequence();
        write_reg(REG_WAKE_BYTES, 16'd2);
        send_txn(rand_item(FN_INIT));
        drive_card(8'h05, R1_IDLE, 1);
        write_reg(REG_INIT_TIMEOUT, 16'd0);
        write_reg(REG_WAKE_BYTES, 16'd0);
        write_reg(REG_BUSY_WAIT, 16'd0);
        send_txn(rand_item(FN_INIT));
        send_txn(rand_item(FN_TICK));
        drive_card(8'h00, 8'h00, 0);
    endtask

    // Card never answers: the poll gives up after the full response window.
    task automatic test_response_limit();
        start_command(6'd17, 32'h0000_0000, 1'b0);
        drive_card(8'h00, 8'h00, 300);
    endtask

    // Largest busy wait and timeout: init keeps retrying cmd0 until the card answers idle.
    task automatic test_elapsed_saturation();
        write_reg(REG_BUSY_WAIT, ELAPSED_MAX);
        write_reg(REG_INIT_TIMEOUT, ELAPSED_MAX);
        write_reg(REG_WAKE_BYTES, 16'd0);
        in_idle_on = 1'b0;
        send_txn(rand_item(FN_INIT));
        repeat (SAT_TICKS) send_txn(rand_item(FN_TICK));
        drive_card(8'h00, R1_IDLE, 0);
        in_idle_on = 1'b1;
    endtask

    // Random commands and inits against a random card, over several register settings.
    task automatic test_random_traffic();
        logic [31:0] w;
        logic [15:0] busy_ms;
        logic [15:0] timeout_ms;
        logic [7:0]  wake;
        in_t         t;
        int          target;
        int          roll;
        effective_count = 0;
        for (int p = 0; p < 5; p++)
        begin
            w = $urandom;
            case (p)
                0:
                begin
                    busy_ms = '0;
                    timeout_ms = '0;
                    wake = '0;
                end
                1:
                begin
                    busy_ms = ELAPSED_MAX;
                    timeout_ms = ELAPSED_MAX;
                    wake = 8'hFF;
                end
                default:
                begin
                    busy_ms = {13'd0, w[2:0]};
                    timeout_ms = {12'd0, w[7:4]};
                    wake = {6'd0, w[9:8]} + 8'd1;
                end
            endcase
            write_reg(REG_BUSY_WAIT, busy_ms);
            write_reg(REG_INIT_TIMEOUT, timeout_ms);
            write_reg(REG_WAKE_BYTES, {8'd0, wake});
            target = (p + 1) * RANDOM_ITEMS / 5;
            while (effective_count < target)
            begin
                // Pick an idling mode per sequence, with some stretches at full rate.
                roll = $urandom_range(0, 9);
                in_idle_on   = (roll > 1);
                out_stall_on = (roll != 0 && roll != 2);
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    send_txn(rand_item(roll < 5 ? FN_RX : FN_TICK));
                    continue;
                end
                t = rand_item(roll < 32 ? FN_INIT : FN_CMD);
                if (roll >= 32 && roll < 50)
                    t.command_index = (roll < 38) ? CMD_IDLE : (roll < 44) ? CMD_IF_COND : CMD_APP;
                send_txn(t);
                while (eng_phase != PH_IDLE)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 6)
                        send_txn(rand_item(FN_TICK));
                    else if (roll < 9)
                        send_txn(rand_item(roll[0] ? FN_INIT : FN_CMD));
                    else
                    begin
                        t = rand_item(FN_RX);
                        t.rx_byte = random_card_byte();
                        send_txn(t);
                    end
                end
            end
        end
        in_idle_on = 1'b1;
        out_stall_on = 1'b1;
    endtask

    // Output side: random stall bursts, off while out_stall_on is clear.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_stall_on && $urandom_range(0, 99) < 25)
                stall_left = pick_gap();
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_spi_out
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (spi_out_due.size() == 0)
            begin
                $display("%0t: unexpected result %h, expected none", $time, out_data);
                mismatch_count++;
            end
            else
            begin
                want = spi_out_due.pop_front();
                check_field("tx_valid", {7'd0, want.tx_valid}, {7'd0, out_data.tx_valid});
                check_field("tx_byte", want.tx_byte, out_data.tx_byte);
                check_field("cs_low", {7'd0, want.cs_low}, {7'd0, out_data.cs_low});
                check_field("done_res", {7'd0, want.done_res}, {7'd0, out_data.done_res});
                check_field("r1_status", want.r1_status, out_data.r1_status);
                check_field("init_error", {7'd0, want.init_error}, {7'd0, out_data.init_error});
            end
        end
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, spi_out_due.size());
            $display("[sd_spi_command_engine_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_command_frame();
        test_ignored_items();
        test_init_sequence();
        test_response_limit();
        test_elapsed_saturation();
        test_random_traffic();

        settle();
        if (mismatch_count == 0)
            $display("[sd_spi_command_engine_unit] OK");
        else
            $display("[sd_spi_command_engine_unit] ERROR");
        $finish;
    end

endmodule
